// ===== design/hhrc_pkg.sv =====
// Shared types, constants and microcode encodings for the heading hold rate controller.
`default_nettype none

package hhrc_pkg;

  localparam int unsigned RATE_FRACTION_BITS_DEF = 8;

  localparam int unsigned CFG_ADDR_W = 4;
  localparam int unsigned CFG_DATA_W = 32;

  localparam int unsigned HEADING_W = 9;
  localparam int unsigned STICK_W   = 10;
  localparam int unsigned TILT_W    = 15;
  localparam int unsigned GAIN_W    = 8;
  localparam int unsigned LIMIT_W   = 10;
  localparam int unsigned ALPHA_W   = 16;
  localparam int unsigned RATE_W    = 19;

  localparam int unsigned DIFF_W    = 10;
  localparam int unsigned DMAG_W    = 8;
  localparam int unsigned PROD_W    = 16;
  localparam int unsigned QUOT_W    = 11;
  localparam int unsigned REM_W     = 5;

  localparam logic signed [DIFF_W-1:0] HALF_TURN = 10'sd180;
  localparam logic signed [DIFF_W-1:0] FULL_TURN = 10'sd360;

  localparam int unsigned GAIN_DIV     = 30;
  localparam int unsigned RECIP_W      = 16;
  localparam logic [RECIP_W-1:0] GAIN_RECIP = 16'd34953;
  localparam int unsigned RECIP_SHIFT  = 20;
  localparam int unsigned ROUND_HALF   = 32768;

  localparam logic [GAIN_W-1:0]  GAIN_RST  = 8'd40;
  localparam logic [LIMIT_W-1:0] LIMIT_RST = 10'd90;
  localparam logic [TILT_W-1:0]  TILT_RST  = 15'd13377;
  localparam logic [ALPHA_W-1:0] ALPHA_RST = 16'd4096;

  typedef enum logic [1:0] {
    REG_GAIN  = 2'd0,
    REG_LIMIT = 2'd1,
    REG_TILT  = 2'd2,
    REG_ALPHA = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [GAIN_W-1:0]  gain;
    logic [LIMIT_W-1:0] rate_limit;
    logic [TILT_W-1:0]  tilt_limit;
    logic [ALPHA_W-1:0] alpha;
  } cfg_regs_t;

  localparam int unsigned PC_W = 3;
  typedef logic [PC_W-1:0] pc_t;

  localparam pc_t PC_LOAD  = 3'd0;
  localparam pc_t PC_GAIN  = 3'd1;
  localparam pc_t PC_RECIP = 3'd2;
  localparam pc_t PC_CLAMP = 3'd3;
  localparam pc_t PC_FMUL  = 3'd4;
  localparam pc_t PC_FACC  = 3'd5;
  localparam pc_t PC_EMIT  = 3'd6;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_GAIN,
    OP_RECIP,
    OP_CLAMP,
    OP_FMUL,
    OP_FACC,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEXT,
    C_WAIT_IN,
    C_SKIP_NO_HOLD,
    C_WAIT_OUT_RET,
    C_JUMP
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ctl_word_t;

  typedef struct packed {
    op_t  op;
    logic fire;
  } step_t;

  typedef struct packed {
    logic hold;
    logic out_busy;
  } dp_stat_t;

endpackage

`default_nettype wire

// ===== design/hhrc_ucode_rom.sv =====
// Microcode program store: one control word per sequencer step.
`default_nettype none

module hhrc_ucode_rom (
  input  wire hhrc_pkg::pc_t       pc,
  output hhrc_pkg::ctl_word_t      ctl
);

  always_comb begin
    unique case (pc)
      hhrc_pkg::PC_LOAD:  ctl = '{hhrc_pkg::OP_LOAD,  hhrc_pkg::C_WAIT_IN,      hhrc_pkg::PC_GAIN};
      hhrc_pkg::PC_GAIN:  ctl = '{hhrc_pkg::OP_GAIN,  hhrc_pkg::C_SKIP_NO_HOLD, hhrc_pkg::PC_EMIT};
      hhrc_pkg::PC_RECIP: ctl = '{hhrc_pkg::OP_RECIP, hhrc_pkg::C_NEXT,         hhrc_pkg::PC_CLAMP};
      hhrc_pkg::PC_CLAMP: ctl = '{hhrc_pkg::OP_CLAMP, hhrc_pkg::C_NEXT,         hhrc_pkg::PC_FMUL};
      hhrc_pkg::PC_FMUL:  ctl = '{hhrc_pkg::OP_FMUL,  hhrc_pkg::C_NEXT,         hhrc_pkg::PC_FACC};
      hhrc_pkg::PC_FACC:  ctl = '{hhrc_pkg::OP_FACC,  hhrc_pkg::C_NEXT,         hhrc_pkg::PC_EMIT};
      hhrc_pkg::PC_EMIT:  ctl = '{hhrc_pkg::OP_EMIT,  hhrc_pkg::C_WAIT_OUT_RET, hhrc_pkg::PC_LOAD};
      default:            ctl = '{hhrc_pkg::OP_NOP,   hhrc_pkg::C_JUMP,         hhrc_pkg::PC_LOAD};
    endcase
  end

endmodule

`default_nettype wire

// ===== design/hhrc_sequencer.sv =====
// Step counter and branch logic that walks the microcode program.
`default_nettype none

module hhrc_sequencer (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  input  wire hhrc_pkg::dp_stat_t stat,
  output logic                 in_ready,
  output hhrc_pkg::step_t      step
);

  hhrc_pkg::pc_t       pc_r;
  hhrc_pkg::pc_t       pc_nxt;
  hhrc_pkg::ctl_word_t ctl;
  hhrc_pkg::pc_t       pc_inc;

  hhrc_ucode_rom u_rom (
    .pc  (pc_r),
    .ctl (ctl)
  );

  assign pc_inc   = pc_r + hhrc_pkg::PC_W'(1);
  assign in_ready = (ctl.cond == hhrc_pkg::C_WAIT_IN);

  always_comb begin
    step.op = ctl.op;
    unique case (ctl.cond)
      hhrc_pkg::C_NEXT: begin
        step.fire = 1'b1;
        pc_nxt    = pc_inc;
      end
      hhrc_pkg::C_WAIT_IN: begin
        step.fire = in_valid;
        pc_nxt    = in_valid ? pc_inc : pc_r;
      end
      hhrc_pkg::C_SKIP_NO_HOLD: begin
        step.fire = 1'b1;
        pc_nxt    = stat.hold ? pc_inc : ctl.target;
      end
      hhrc_pkg::C_WAIT_OUT_RET: begin
        step.fire = !stat.out_busy;
        pc_nxt    = stat.out_busy ? pc_r : ctl.target;
      end
      hhrc_pkg::C_JUMP: begin
        step.fire = 1'b1;
        pc_nxt    = ctl.target;
      end
      default: begin
        step.fire = 1'b0;
        pc_nxt    = hhrc_pkg::PC_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= hhrc_pkg::PC_LOAD;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== design/hhrc_datapath.sv =====
// Datapath: heading error, gain scaling, clamp, low-pass filter and result register.
`default_nettype none

module hhrc_datapath #(
  parameter int unsigned RATE_FRACTION_BITS = hhrc_pkg::RATE_FRACTION_BITS_DEF
) (
  input  wire                                     clk,
  input  wire                                     rst_n,
  input  wire hhrc_pkg::step_t                    step,
  input  wire hhrc_pkg::cfg_regs_t                cfg,
  input  wire [hhrc_pkg::HEADING_W-1:0]           in_yaw_heading,
  input  wire                                     in_armed,
  input  wire                                     in_hold_mode_active,
  input  wire                                     in_autopilot_enabled,
  input  wire signed [hhrc_pkg::STICK_W-1:0]      in_yaw_stick,
  input  wire [hhrc_pkg::TILT_W-1:0]              in_tilt_cosine,
  input  wire                                     out_stall,
  output logic                                    out_valid,
  output logic signed [hhrc_pkg::RATE_W-1:0]      out_rate_command,
  output logic                                    out_hold_applied,
  output hhrc_pkg::dp_stat_t                      stat
);

  localparam int unsigned F      = RATE_FRACTION_BITS;
  localparam int unsigned Q_W    = hhrc_pkg::QUOT_W + F;
  localparam int unsigned E_W    = Q_W + 1;
  localparam int unsigned FV_W   = Q_W + 1;
  localparam int unsigned D_W    = FV_W + 1;
  localparam int unsigned P_W    = D_W + hhrc_pkg::ALPHA_W + 1;
  localparam int unsigned OUT_W  = hhrc_pkg::RATE_W;
  localparam int unsigned RP_W   = hhrc_pkg::PROD_W + hhrc_pkg::RECIP_W;
  localparam int unsigned TBL_N  = 1 << hhrc_pkg::REM_W;

  logic [F-1:0] frac_tbl [TBL_N];

  for (genvar gi = 0; gi < TBL_N; gi++) begin : g_frac
    localparam int unsigned VAL = (gi << F) / hhrc_pkg::GAIN_DIV;
    assign frac_tbl[gi] = F'(VAL);
  end

  logic                               hold_r, hold_nxt;
  logic                               dneg_r, dneg_nxt;
  logic [hhrc_pkg::DMAG_W-1:0]        dmag_r, dmag_nxt;
  logic [hhrc_pkg::HEADING_W-1:0]     target_r, target_nxt;
  logic [hhrc_pkg::PROD_W-1:0]        m_r, m_nxt;
  logic [hhrc_pkg::QUOT_W-1:0]        a_r, a_nxt;
  logic signed [E_W-1:0]              e_r, e_nxt;
  logic signed [P_W-1:0]              p_r, p_nxt;
  logic signed [FV_W-1:0]             fv_r, fv_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic signed [OUT_W-1:0]            out_rate_r, out_rate_nxt;
  logic                               out_hold_r, out_hold_nxt;

  logic [hhrc_pkg::HEADING_W-1:0]     tgt_eff;
  logic signed [hhrc_pkg::DIFF_W-1:0] d_raw, d_w1, d_w2, d_neg;
  logic                               hold_now;
  logic [RP_W-1:0]                    recip_prod;
  logic [hhrc_pkg::PROD_W-1:0]        a_ext, a_times;
  logic [hhrc_pkg::PROD_W-1:0]        rem_full;
  logic [Q_W-1:0]                     quot, lim, mag;
  logic signed [D_W-1:0]              diff;
  logic signed [P_W-1:0]              alpha_s;
  logic signed [P_W:0]                rsum, rsh;
  logic [FV_W:0]                      inc, fv_sum;
  logic [FV_W+OUT_W-1:0]              rate_ext;

  assign stat.hold     = hold_r;
  assign stat.out_busy = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_rate_command = out_rate_r;
  assign out_hold_applied = out_hold_r;

  always_comb begin
    tgt_eff  = in_armed ? target_r : in_yaw_heading;
    hold_now = in_hold_mode_active && in_autopilot_enabled &&
               (in_yaw_stick == '0) && (in_tilt_cosine >= cfg.tilt_limit);
    d_raw    = signed'({1'b0, in_yaw_heading}) - signed'({1'b0, tgt_eff});
    d_w1     = (d_raw <= -hhrc_pkg::HALF_TURN) ? d_raw + hhrc_pkg::FULL_TURN : d_raw;
    d_w2     = (d_w1 >= hhrc_pkg::HALF_TURN) ? d_w1 - hhrc_pkg::FULL_TURN : d_w1;
    d_neg    = -d_w2;

    recip_prod = RP_W'(m_r) * RP_W'(hhrc_pkg::GAIN_RECIP);

    a_ext    = hhrc_pkg::PROD_W'(a_r);
    a_times  = (a_ext << 5) - (a_ext << 1);
    rem_full = m_r - a_times;
    quot     = {a_r, frac_tbl[rem_full[hhrc_pkg::REM_W-1:0]]};
    lim      = {1'b0, cfg.rate_limit, {F{1'b0}}};
    mag      = (quot > lim) ? lim : quot;

    diff     = D_W'(e_r) - D_W'(fv_r);
    alpha_s  = signed'(P_W'(cfg.alpha));

    rsum     = (P_W + 1)'(p_r) + signed'((P_W + 1)'(hhrc_pkg::ROUND_HALF));
    rsh      = rsum >>> hhrc_pkg::ALPHA_W;
    inc      = rsh[FV_W:0];
    fv_sum   = {fv_r[FV_W-1], fv_r} + inc;

    rate_ext = {{OUT_W{fv_r[FV_W-1]}}, fv_r};
  end

  always_comb begin
    hold_nxt      = hold_r;
    dneg_nxt      = dneg_r;
    dmag_nxt      = dmag_r;
    target_nxt    = target_r;
    m_nxt         = m_r;
    a_nxt         = a_r;
    e_nxt         = e_r;
    p_nxt         = p_r;
    fv_nxt        = fv_r;
    out_rate_nxt  = out_rate_r;
    out_hold_nxt  = out_hold_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (step.fire) begin
      unique case (step.op)
        hhrc_pkg::OP_LOAD: begin
          hold_nxt = hold_now;
          dneg_nxt = d_w2[hhrc_pkg::DIFF_W-1];
          dmag_nxt = d_w2[hhrc_pkg::DIFF_W-1] ? d_neg[hhrc_pkg::DMAG_W-1:0]
                                              : d_w2[hhrc_pkg::DMAG_W-1:0];
          if (!in_armed) begin
            target_nxt = in_yaw_heading;
            fv_nxt     = '0;
          end
        end
        hhrc_pkg::OP_GAIN:  m_nxt = hhrc_pkg::PROD_W'(dmag_r) * hhrc_pkg::PROD_W'(cfg.gain);
        hhrc_pkg::OP_RECIP: a_nxt = recip_prod[hhrc_pkg::RECIP_SHIFT +: hhrc_pkg::QUOT_W];
        hhrc_pkg::OP_CLAMP: begin
          e_nxt = dneg_r ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
        end
        hhrc_pkg::OP_FMUL:  p_nxt  = P_W'(diff) * alpha_s;
        hhrc_pkg::OP_FACC:  fv_nxt = fv_sum[FV_W-1:0];
        hhrc_pkg::OP_EMIT: begin
          out_valid_nxt = 1'b1;
          out_hold_nxt  = hold_r;
          out_rate_nxt  = hold_r ? rate_ext[OUT_W-1:0] : '0;
        end
        hhrc_pkg::OP_NOP: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hold_r      <= 1'b0;
      target_r    <= '0;
      fv_r        <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hold_r      <= hold_nxt;
      target_r    <= target_nxt;
      fv_r        <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dneg_r     <= dneg_nxt;
    dmag_r     <= dmag_nxt;
    m_r        <= m_nxt;
    a_r        <= a_nxt;
    e_r        <= e_nxt;
    p_r        <= p_nxt;
    out_rate_r <= out_rate_nxt;
    out_hold_r <= out_hold_nxt;
  end

endmodule

`default_nettype wire

// ===== design/heading_hold_rate_controller.sv =====
// Top level: configuration registers, microcode sequencer and datapath.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+------------------------------------------
//  in      | input     | in_valid/in_stall | yaw_heading, armed, mode flags, stick, tilt
//  out     | output    | out_valid/out_stall | rate_command, hold_applied
//  cfg     | input     | psel/penable/pready | paddr, pwdata, prdata
//
//  The microcode program has seven steps; an item without hold skips from the gain step
//  to the emit step. The emit step loads the result into the output register; the next
//  item is accepted in the cycle after the result is loaded at the earliest, so the block
//  does not take a new item before it is through with the last one.
//  A stalled result waits in the output register while the next item is accepted and runs
//  up to the emit step; the input then stalls until the waiting result moves on.
//  Reset is synchronous; it restores register defaults and clears target and filter state.
`default_nettype none

module heading_hold_rate_controller #(
  parameter int unsigned RATE_FRACTION_BITS = hhrc_pkg::RATE_FRACTION_BITS_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  in_valid,
  output logic                                 in_stall,
  input  wire [hhrc_pkg::HEADING_W-1:0]        in_yaw_heading,
  input  wire                                  in_armed,
  input  wire                                  in_hold_mode_active,
  input  wire                                  in_autopilot_enabled,
  input  wire signed [hhrc_pkg::STICK_W-1:0]   in_yaw_stick,
  input  wire [hhrc_pkg::TILT_W-1:0]           in_tilt_cosine,
  output logic                                 out_valid,
  input  wire                                  out_stall,
  output logic signed [hhrc_pkg::RATE_W-1:0]   out_rate_command,
  output logic                                 out_hold_applied,
  input  wire                                  psel,
  input  wire                                  penable,
  input  wire                                  pwrite,
  input  wire [hhrc_pkg::CFG_ADDR_W-1:0]       paddr,
  input  wire [hhrc_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [hhrc_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  hhrc_pkg::cfg_regs_t cfg_r, cfg_nxt;
  hhrc_pkg::reg_idx_t  reg_idx;
  hhrc_pkg::step_t     step;
  hhrc_pkg::dp_stat_t  stat;
  logic                in_ready;
  logic                wr_en;

  assign pready   = 1'b1;
  assign in_stall = !in_ready;
  assign reg_idx  = hhrc_pkg::reg_idx_t'(paddr[hhrc_pkg::CFG_ADDR_W-1:2]);
  assign wr_en    = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (reg_idx)
        hhrc_pkg::REG_GAIN:  cfg_nxt.gain       = pwdata[hhrc_pkg::GAIN_W-1:0];
        hhrc_pkg::REG_LIMIT: cfg_nxt.rate_limit = pwdata[hhrc_pkg::LIMIT_W-1:0];
        hhrc_pkg::REG_TILT:  cfg_nxt.tilt_limit = pwdata[hhrc_pkg::TILT_W-1:0];
        hhrc_pkg::REG_ALPHA: cfg_nxt.alpha      = pwdata[hhrc_pkg::ALPHA_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      hhrc_pkg::REG_GAIN:  prdata = hhrc_pkg::CFG_DATA_W'(cfg_r.gain);
      hhrc_pkg::REG_LIMIT: prdata = hhrc_pkg::CFG_DATA_W'(cfg_r.rate_limit);
      hhrc_pkg::REG_TILT:  prdata = hhrc_pkg::CFG_DATA_W'(cfg_r.tilt_limit);
      hhrc_pkg::REG_ALPHA: prdata = hhrc_pkg::CFG_DATA_W'(cfg_r.alpha);
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain       <= hhrc_pkg::GAIN_RST;
      cfg_r.rate_limit <= hhrc_pkg::LIMIT_RST;
      cfg_r.tilt_limit <= hhrc_pkg::TILT_RST;
      cfg_r.alpha      <= hhrc_pkg::ALPHA_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  hhrc_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .stat     (stat),
    .in_ready (in_ready),
    .step     (step)
  );

  hhrc_datapath #(
    .RATE_FRACTION_BITS (RATE_FRACTION_BITS)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .step                 (step),
    .cfg                  (cfg_r),
    .in_yaw_heading       (in_yaw_heading),
    .in_armed             (in_armed),
    .in_hold_mode_active  (in_hold_mode_active),
    .in_autopilot_enabled (in_autopilot_enabled),
    .in_yaw_stick         (in_yaw_stick),
    .in_tilt_cosine       (in_tilt_cosine),
    .out_stall            (out_stall),
    .out_valid            (out_valid),
    .out_rate_command     (out_rate_command),
    .out_hold_applied     (out_hold_applied),
    .stat                 (stat)
  );

endmodule

`default_nettype wire

// ===== design/hhrc_checker.sv =====
// Port-level assertions for the heading hold rate controller, bound to the top level.
`default_nettype none

module hhrc_checker (
  input wire                                clk,
  input wire                                rst_n,
  input wire                                in_valid,
  input wire                                in_stall,
  input wire                                out_valid,
  input wire                                out_stall,
  input wire signed [hhrc_pkg::RATE_W-1:0]  out_rate_command,
  input wire                                out_hold_applied
);

  a_out_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rate_command) &&
                               $stable(out_hold_applied))
    else $error("stalled item changed");

  a_zero_without_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hold_applied |-> out_rate_command == '0)
    else $error("nonzero rate without hold");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");

  a_ready_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("not ready after result load");

endmodule

bind heading_hold_rate_controller hhrc_checker u_hhrc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_rate_command (out_rate_command),
  .out_hold_applied (out_hold_applied)
);

`default_nettype wire
